FILE: rtl/llss_pkg.sv
`timescale 1ns / 1ps

package llss_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 16;
  localparam int CFG_W       = 5;
  localparam int MODE_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_OK        = 2'd0,
    MODE_FAILED    = 2'd1,
    MODE_CONN_LOST = 2'd2
  } mode_e;

  // Health update broadcast to every cell; only the addressed cell has wr_en set.
  typedef struct packed {
    logic             wr_en;
    mode_e            mode;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] errors;
  } upd_t;

  // Running best candidate that walks down the row of cells.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] errors;
  } cand_t;

endpackage

FILE: rtl/least_loaded_server_selector.sv
`timescale 1ns / 1ps

// Least-loaded server selector. Each server entry lives in its own cell of a
// row of MAX_SERVERS cells. An accepted update request is written into the
// addressed cell at once; a compare token then walks the row, one cell per
// cycle, carrying the best live entry found so far. The finished scan passes
// through a pending stage into the output register, and the next request is
// not accepted until the pending stage has handed its result on. While the
// output is stalled and still holds the earlier result, the finished scan
// waits in the pending stage. The result sits in an output register, and the
// next request is accepted while that result still waits. The server_count
// register may only be written while no request is in flight.
module least_loaded_server_selector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [llss_pkg::CFG_W-1:0]     server_count_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [llss_pkg::MODE_W-1:0]    mode_i,
  input  logic [llss_pkg::IDX_W-1:0]     server_index_i,
  input  logic [llss_pkg::CNT_W-1:0]     reported_errors_i,
  input  logic [llss_pkg::CNT_W-1:0]     reported_total_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [llss_pkg::IDX_W-1:0]     best_index_o,
  output logic                           none_alive_o
);
  import llss_pkg::*;

  logic [CFG_W-1:0]       server_count_q;
  logic                   busy_q;
  logic                   start_q;
  logic                   in_accept;
  cand_t                  chain [MAX_SERVERS+1];
  logic [MAX_SERVERS-1:0] in_use;
  logic [MAX_SERVERS-1:0] tokens;
  upd_t                   upd [MAX_SERVERS];
  cand_t                  pend_q;
  logic                   pend_move;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       best_index_q;
  logic                   none_alive_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_accept   = in_valid_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      server_count_q <= server_count_i;
    end
  end

  assign chain[0].valid  = start_q;
  assign chain[0].found  = 1'b0;
  assign chain[0].idx    = '0;
  assign chain[0].total  = '0;
  assign chain[0].errors = '0;

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    // Entries at or above the register value, or beyond the 4-bit index, sit out.
    assign in_use[i]      = (int'(server_count_q) > i) && (i < 16);
    assign tokens[i]      = chain[i+1].valid;
    assign upd[i].wr_en   = in_accept && (int'(server_index_i) == i);
    assign upd[i].mode    = mode_e'(mode_i);
    assign upd[i].total   = reported_total_i;
    assign upd[i].errors  = reported_errors_i;

    llss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_i      (upd[i]),
      .in_use_i   (in_use[i]),
      .cell_idx_i (IDX_W'(i)),
      .cand_i     (chain[i]),
      .cand_o     (chain[i+1])
    );
  end

  // The pending stage holds a finished scan until the output register is free.
  assign pend_move = pend_q.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      best_index_q <= '0;
      none_alive_q <= 1'b0;
    end else begin
      start_q <= in_accept;
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (pend_move) begin
        busy_q <= 1'b0;
      end

      if (chain[MAX_SERVERS].valid) begin
        pend_q <= chain[MAX_SERVERS];
      end else if (pend_move) begin
        pend_q.valid <= 1'b0;
      end

      if (pend_move) begin
        out_valid_q  <= 1'b1;
        best_index_q <= pend_q.found ? pend_q.idx : '0;
        none_alive_q <= !pend_q.found;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_index_o = best_index_q;
  assign none_alive_o = none_alive_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tokens))
    else $error("more than one compare token in the cell row");

  a_stall_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || (tokens != '0) || pend_q.valid) |-> in_stall_o)
    else $error("request accepted while a scan is in flight");

  a_pend_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_SERVERS].valid |-> !pend_q.valid)
    else $error("finished scan would overwrite a pending result");

  a_pend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q.valid && !pend_move) |=> pend_q.valid)
    else $error("pending result lost");
`endif

endmodule

FILE: rtl/llss_cell.sv
`timescale 1ns / 1ps

module llss_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  llss_pkg::upd_t                upd_i,
  input  logic                          in_use_i,
  input  logic [llss_pkg::IDX_W-1:0]    cell_idx_i,
  input  llss_pkg::cand_t               cand_i,
  output llss_pkg::cand_t               cand_o
);
  import llss_pkg::*;

  logic             alive_q;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] errors_q;
  logic             better;
  cand_t            cand_d;
  cand_t            cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q  <= 1'b0;
      total_q  <= '0;
      errors_q <= '0;
    end else if (upd_i.wr_en) begin
      case (upd_i.mode)
        MODE_OK: begin
          alive_q  <= 1'b1;
          total_q  <= upd_i.total;
          errors_q <= upd_i.errors;
        end
        MODE_FAILED: begin
          alive_q  <= 1'b0;
          total_q  <= total_q + CNT_W'(1);
          errors_q <= errors_q + CNT_W'(1);
        end
        MODE_CONN_LOST: begin
          alive_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Strict comparisons keep the earlier (lower) index on a full tie.
  assign better = alive_q && in_use_i &&
                  (!cand_i.found || (total_q < cand_i.total) ||
                   ((total_q == cand_i.total) && (errors_q < cand_i.errors)));

  always_comb begin
    cand_d = cand_i;
    if (better) begin
      cand_d.found  = 1'b1;
      cand_d.idx    = cell_idx_i;
      cand_d.total  = total_q;
      cand_d.errors = errors_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

FILE: tb/sv/tb_least_loaded_server_selector.sv
`timescale 1ns / 1ps

module tb_least_loaded_server_selector;
  import llss_pkg::*;

  // The fourth mode code has no name in the package; the block must leave the table alone.
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT = 12;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [IDX_W-1:0] best;
    logic             none;
  } pick_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CFG_W-1:0]  count;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  errors;
    logic [CNT_W-1:0]  total;
    logic              typed;
    pick_t             pick;
  } row_t;

  // Rows with typed set carry a result that is plain from the table contents.
  localparam row_t DIRECTED [21] = '{
    '{1'b0, 5'd0, MODE_CONN_LOST, 4'd0, 16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b1}},
    '{1'b0, 5'd0, MODE_OK, 4'd0, 16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd5, 16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_FAILED, 4'd0, 16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b1}},
    '{1'b1, 5'd16, MODE_OK, 4'd0, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_RESERVED, 4'd3, 16'h0000, 16'h0000, 1'b1, '{4'd5, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, '{4'd5, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd2, 16'h0000, 16'h0000, 1'b1, '{4'd2, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd2, 16'h0001, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_FAILED, 4'd15, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_CONN_LOST, 4'd5, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd14, 16'h0000, 16'hFFFF, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd13, 16'hFFFF, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b1, 5'd0, MODE_OK, 4'd0, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_RESERVED, 4'd0, 16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b1}},
    '{1'b1, 5'd31, MODE_OK, 4'd0, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd1, 16'h00FF, 16'hFF00, 1'b0, '{4'd0, 1'b0}},
    '{1'b1, 5'd3, MODE_OK, 4'd0, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_OK, 4'd9, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b0, 5'd0, MODE_FAILED, 4'd2, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
    '{1'b1, 5'd1, MODE_OK, 4'd0, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  server_count_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic [IDX_W-1:0]  server_index_i = '0;
  logic [CNT_W-1:0]  reported_errors_i = '0;
  logic [CNT_W-1:0]  reported_total_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [IDX_W-1:0]  best_index_o;
  logic              none_alive_o;

  // Typed expectation that travels with the request currently on the input.
  logic              row_typed = 1'b0;
  pick_t             row_pick = '0;

  // Health table as the block should hold it.
  logic              health_alive [MAX_SERVERS];
  logic [CNT_W-1:0]  health_total [MAX_SERVERS];
  logic [CNT_W-1:0]  health_errors [MAX_SERVERS];
  logic [CFG_W-1:0]  entries_cfg = 5'd1;

  pick_t             expected_picks [$];
  int                mismatches = 0;
  int                quiet_cycles = 0;
  int                idle_pct = IDLE_PERCENT;
  int                cur_count = 1;

  least_loaded_server_selector u_top (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .server_count_i    (server_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .server_index_i    (server_index_i),
    .reported_errors_i (reported_errors_i),
    .reported_total_i  (reported_total_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .best_index_o      (best_index_o),
    .none_alive_o      (none_alive_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic pick_t apply_and_pick(input logic [MODE_W-1:0] m,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [CNT_W-1:0] errors,
                                           input logic [CNT_W-1:0] total);
    pick_t            pick;
    int               n;
    logic             found;
    logic [CNT_W-1:0] best_total;
    logic [CNT_W-1:0] best_errors;
    if (idx < MAX_SERVERS) begin
      case (m)
        MODE_OK: begin
          health_alive[idx] = 1'b1;
          health_total[idx] = total;
          health_errors[idx] = errors;
        end
        MODE_FAILED: begin
          health_alive[idx] = 1'b0;
          health_total[idx] = health_total[idx] + 1'b1;
          health_errors[idx] = health_errors[idx] + 1'b1;
        end
        MODE_CONN_LOST: begin
          health_alive[idx] = 1'b0;
        end
        default: ;
      endcase
    end
    n = entries_cfg;
    if (n > MAX_SERVERS) n = MAX_SERVERS;
    if (n > (1 << IDX_W)) n = 1 << IDX_W;
    found = 1'b0;
    pick = '0;
    best_total = '0;
    best_errors = '0;
    for (int i = 0; i < n; i++) begin
      if (health_alive[i] && (!found || health_total[i] < best_total ||
          (health_total[i] == best_total && health_errors[i] < best_errors))) begin
        found = 1'b1;
        pick.best = IDX_W'(i);
        best_total = health_total[i];
        best_errors = health_errors[i];
      end
    end
    pick.none = !found;
    return pick;
  endfunction

  // Counts cluster near zero so that ties on the total and on the errors are common.
  function automatic logic [CNT_W-1:0] random_count();
    int r;
    r = $urandom_range(99);
    if (r < 50) return CNT_W'($urandom_range(3));
    if (r < 70) return ($urandom_range(1) != 0) ? '1 : '0;
    return CNT_W'($urandom);
  endfunction

  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        health_alive[i] = 1'b0;
        health_total[i] = '0;
        health_errors[i] = '0;
      end
      entries_cfg = 5'd1;
    end else begin
      if (cfg_valid_i && cfg_ready_o) entries_cfg = server_count_i;
      if (out_valid_o && !out_stall_i) begin
        got.best = best_index_o;
        got.none = none_alive_o;
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: best %0d none %0d",
                     $time, got.best, got.none);
        end else begin
          want = expected_picks.pop_front();
          if (got.best !== want.best || got.none !== want.none) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected best %0d none %0d, got best %0d none %0d",
                       $time, want.best, want.none, got.best, got.none);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = apply_and_pick(mode_i, server_index_i, reported_errors_i, reported_total_i);
        if (row_typed) want = row_pick;
        expected_picks.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < idle_pct);
  end

  // Called and returning at a falling edge; valid stays high between back-to-back requests.
  task automatic send_update(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                             input logic [CNT_W-1:0] errors, input logic [CNT_W-1:0] total,
                             input logic typed, input pick_t pick);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    server_index_i <= idx;
    reported_errors_i <= errors;
    reported_total_i <= total;
    row_typed <= typed;
    row_pick <= pick;
    @(posedge clk);
    while (!(in_valid_i && !in_stall_o)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_server_count(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_picks.size() != 0) @(negedge clk);
    cfg_valid_i <= 1'b1;
    server_count_i <= value;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
    cur_count = value;
  endtask

  task automatic send_random_update();
    logic [MODE_W-1:0] m;
    logic [IDX_W-1:0]  idx;
    int                r;
    int                n;
    r = $urandom_range(99);
    if (r < 55) m = MODE_OK;
    else if (r < 75) m = MODE_FAILED;
    else if (r < 90) m = MODE_CONN_LOST;
    else m = MODE_RESERVED;
    n = (cur_count > MAX_SERVERS) ? MAX_SERVERS : cur_count;
    if (n > 0 && $urandom_range(99) < 80) idx = IDX_W'($urandom_range(n - 1));
    else idx = IDX_W'($urandom_range(MAX_SERVERS - 1));
    send_update(m, idx, random_count(), random_count(), 1'b0, '0);
  endtask

  initial begin
    logic [CFG_W-1:0] count;
    repeat (11) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        write_server_count(DIRECTED[i].count);
      end else begin
        send_update(DIRECTED[i].mode, DIRECTED[i].idx, DIRECTED[i].errors,
                    DIRECTED[i].total, DIRECTED[i].typed, DIRECTED[i].pick);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) count = 5'd16;
      else if (p == 1) count = 5'd1;
      else if (p == 2) count = 5'd31;
      else if ($urandom_range(99) < 75) count = CFG_W'($urandom_range(16, 1));
      else count = CFG_W'($urandom_range(31));
      // Two phases run with neither side ever idling.
      idle_pct = (p == 4 || p == 5) ? 0 : IDLE_PERCENT;
      write_server_count(count);
      repeat (PHASE_ITEMS) send_random_update();
    end
    in_valid_i <= 1'b0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (2 * MAX_SERVERS + 4) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
